// ===== hdl/nmk_pkg.sv =====
package nmk_pkg;

	// Fixed field widths of the stream words.
	localparam int WORD_BITS  = 32;
	localparam int TAG_BITS   = 32;
	localparam int KEY_BITS   = 64;
	localparam int FRAC_BITS  = 31;  // quotient bits, one per divider cell
	localparam int IN_BITS    = 96;
	localparam int OUT_BITS   = 96;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HIGH = 2'd1;

	// Side data that rides along the divider chain unchanged.
	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic                oob;
	} side_t;

	// Place fx on the even key bits and fy on the odd key bits.
	function automatic logic [KEY_BITS-1:0] interleave(
		input logic [WORD_BITS-1:0] fx,
		input logic [WORD_BITS-1:0] fy
	);
		logic [KEY_BITS-1:0] key;
		for (int i = 0; i < WORD_BITS; i++) begin
			key[2*i]   = fx[i];
			key[2*i+1] = fy[i];
		end
		return key;
	endfunction

endpackage

// ===== hdl/nmk_front.sv =====
module nmk_front #(
	parameter int CB = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [CB-1:0]       x_coord,
	input  logic [CB-1:0]       y_coord,
	input  logic [nmk_pkg::TAG_BITS-1:0] point_tag,
	input  logic [CB-1:0]       box_low,
	input  logic [CB-1:0]       box_high,
	output logic                valid_s1,
	output nmk_pkg::side_t      side_s1,
	output logic [CB-1:0]       off_x_s1,
	output logic [CB-1:0]       off_y_s1,
	output logic [CB:0]         span_s1
);

	logic          inverted;
	logic [CB-1:0] hi_eff;
	logic [CB-1:0] span_m1;
	logic          x_lo, x_hi, y_lo, y_hi;
	logic [CB-1:0] off_x, off_y;

	// An inverted box collapses onto the single value box_low.
	assign inverted = box_high < box_low;
	assign hi_eff   = inverted ? box_low : box_high;
	assign span_m1  = inverted ? '0 : box_high - box_low;

	assign x_lo = x_coord < box_low;
	assign x_hi = x_coord > hi_eff;
	assign y_lo = y_coord < box_low;
	assign y_hi = y_coord > hi_eff;

	// Offset of the clamped coordinate from the low edge.
	assign off_x = x_lo ? '0 : (x_hi ? span_m1 : x_coord - box_low);
	assign off_y = y_lo ? '0 : (y_hi ? span_m1 : y_coord - box_low);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.tag <= point_tag;
			side_s1.oob <= x_lo | x_hi | y_lo | y_hi;
			off_x_s1    <= off_x;
			off_y_s1    <= off_y;
			span_s1     <= {1'b0, span_m1} + {{CB{1'b0}}, 1'b1};
		end
	end

endmodule

// ===== hdl/nmk_div_cell.sv =====
module nmk_div_cell #(
	parameter int CB = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  nmk_pkg::side_t                    in_side,
	input  logic [CB-1:0]                     in_rem_x,
	input  logic [CB-1:0]                     in_rem_y,
	input  logic [CB:0]                       in_span,
	input  logic [nmk_pkg::FRAC_BITS-1:0]     in_quo_x,
	input  logic [nmk_pkg::FRAC_BITS-1:0]     in_quo_y,
	output logic                              valid_q,
	output nmk_pkg::side_t                    side_q,
	output logic [CB-1:0]                     rem_x_q,
	output logic [CB-1:0]                     rem_y_q,
	output logic [CB:0]                       span_q,
	output logic [nmk_pkg::FRAC_BITS-1:0]     quo_x_q,
	output logic [nmk_pkg::FRAC_BITS-1:0]     quo_y_q
);

	// One restoring step per lane: the remainder stays below the span,
	// so twice the remainder fits in CB+1 bits.
	logic [CB:0] dbl_x, dbl_y;
	logic [CB:0] dif_x, dif_y;
	logic        ge_x, ge_y;

	assign dbl_x = {in_rem_x, 1'b0};
	assign dbl_y = {in_rem_y, 1'b0};
	assign ge_x  = dbl_x >= in_span;
	assign ge_y  = dbl_y >= in_span;
	assign dif_x = ge_x ? dbl_x - in_span : dbl_x;
	assign dif_y = ge_y ? dbl_y - in_span : dbl_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q  <= in_side;
			rem_x_q <= dif_x[CB-1:0];
			rem_y_q <= dif_y[CB-1:0];
			span_q  <= in_span;
			quo_x_q <= {in_quo_x[nmk_pkg::FRAC_BITS-2:0], ge_x};
			quo_y_q <= {in_quo_y[nmk_pkg::FRAC_BITS-2:0], ge_y};
		end
	end

endmodule

// ===== hdl/normalized_morton_key.sv =====
// Normalized 2-D Morton key. Each input word carries a point (x, y, tag);
// both coordinates are clamped into the box [box_low, box_high] shared by
// the two axes, turned into the 32-bit fraction
// floor((c - box_low) * 2^31 / (box_high - box_low + 1)) * 2, and the two
// fractions are interleaved into a 64-bit key with x on the even bits and
// y on the odd bits. The tag passes through and out_of_box flags a point
// that needed clamping. If box_high is below box_low, the box shrinks to
// the single value box_low. The block takes one word per clock and gives
// one key per clock while the output buffer has a free slot. A word
// passes 33 registers in order: the clamp and offset register, the 31
// divider cells (each settles one quotient bit for both axes) and the
// output register, whose load raises m_tvalid. A two-entry output buffer
// lets the chain keep moving for one more word after the consumer stalls.
// Only the low COORD_BITS bits of coordinates and bounds are used. Write
// the box registers only while the block is empty.
module normalized_morton_key #(
	parameter int COORD_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nmk_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [nmk_pkg::WORD_BITS-1:0]        cfg_data,
	// Input stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: x_coord[31:0], y_coord[63:32], point_tag[95:64].
	input  logic [nmk_pkg::IN_BITS-1:0]          s_tdata,
	// Output stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Fields from bit 0: z_key[63:0], tag_out[95:64].
	output logic [nmk_pkg::OUT_BITS-1:0]         m_tdata,
	// Fields from bit 0: out_of_box[0].
	output logic                                 m_tuser
);

	localparam int CB    = COORD_BITS;
	localparam int CELLS = nmk_pkg::FRAC_BITS;
	localparam int WB    = nmk_pkg::WORD_BITS;

	// Box registers, kept at the coordinate width.
	logic [CB-1:0] box_low_q;
	logic [CB-1:0] box_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_low_q  <= '0;
			box_high_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nmk_pkg::REG_BOX_LOW:  box_low_q  <= cfg_data[CB-1:0];
				nmk_pkg::REG_BOX_HIGH: box_high_q <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	// The whole chain moves together whenever the output buffer has a
	// free slot, so the input is ready under the same condition.
	logic skid_valid_q;
	logic adv;

	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	// Stage 0 is the front end; stage k is the output of divider cell k.
	logic                          valid_c [0:CELLS];
	nmk_pkg::side_t                side_c  [0:CELLS];
	logic [CB-1:0]                 rem_x_c [0:CELLS];
	logic [CB-1:0]                 rem_y_c [0:CELLS];
	logic [CB:0]                   span_c  [0:CELLS];
	logic [nmk_pkg::FRAC_BITS-1:0] quo_x_c [0:CELLS];
	logic [nmk_pkg::FRAC_BITS-1:0] quo_y_c [0:CELLS];

	nmk_front #(.CB(CB)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.x_coord   (s_tdata[CB-1:0]),
		.y_coord   (s_tdata[WB+CB-1:WB]),
		.point_tag (s_tdata[3*WB-1:2*WB]),
		.box_low   (box_low_q),
		.box_high  (box_high_q),
		.valid_s1  (valid_c[0]),
		.side_s1   (side_c[0]),
		.off_x_s1  (rem_x_c[0]),
		.off_y_s1  (rem_y_c[0]),
		.span_s1   (span_c[0])
	);

	// The quotient entering the first cell has no meaningful bits yet;
	// all of them are shifted out by the end of the chain.
	assign quo_x_c[0] = '0;
	assign quo_y_c[0] = '0;

	for (genvar k = 1; k <= CELLS; k++) begin : g_cell
		nmk_div_cell #(.CB(CB)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (valid_c[k-1]),
			.in_side  (side_c[k-1]),
			.in_rem_x (rem_x_c[k-1]),
			.in_rem_y (rem_y_c[k-1]),
			.in_span  (span_c[k-1]),
			.in_quo_x (quo_x_c[k-1]),
			.in_quo_y (quo_y_c[k-1]),
			.valid_q  (valid_c[k]),
			.side_q   (side_c[k]),
			.rem_x_q  (rem_x_c[k]),
			.rem_y_q  (rem_y_c[k]),
			.span_q   (span_c[k]),
			.quo_x_q  (quo_x_c[k]),
			.quo_y_q  (quo_y_c[k])
		);
	end

	// Finished word: fractions are the quotients with a zero below them.
	logic [nmk_pkg::OUT_BITS-1:0] done_data;
	logic                         done_user;
	logic                         done_valid;

	assign done_data  = {side_c[CELLS].tag,
		nmk_pkg::interleave({quo_x_c[CELLS], 1'b0}, {quo_y_c[CELLS], 1'b0})};
	assign done_user  = side_c[CELLS].oob;
	assign done_valid = valid_c[CELLS] && adv;

	// Output register plus one skid entry. While the skid entry is full
	// the chain holds, so no new word can arrive at the same time.
	logic                         out_valid_q;
	logic [nmk_pkg::OUT_BITS-1:0] out_data_q;
	logic                         out_user_q;
	logic [nmk_pkg::OUT_BITS-1:0] skid_data_q;
	logic                         skid_user_q;
	logic                         out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || done_valid;
			skid_valid_q <= 1'b0;
		end else if (done_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : done_data;
			out_user_q <= skid_valid_q ? skid_user_q : done_user;
		end else if (done_valid) begin
			skid_data_q <= done_data;
			skid_user_q <= done_user;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// A word waits in the skid entry only behind a word in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while output register is empty");

	// The skid entry fills only when the output word was stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid entry filled without a stalled output");

	// A stalled output with a full skid entry freezes the divider chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !m_tready) |=> $stable(valid_c[CELLS]) && skid_valid_q)
		else $error("divider chain moved while the output was blocked");

endmodule
